// File: rtl/rbmm_pkg.sv
// ----------------------------------------------------------------------------
// rbmm_pkg
// Shared widths, register indexes and controller states for the row band
// matrix multiply core.
// ----------------------------------------------------------------------------
package rbmm_pkg;

    localparam int MAX_SIZE   = 8;

    localparam int ELEM_W     = 16;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int SUM_W      = 35;
    localparam int ROW_W      = 3;

    localparam int SIZE_W     = 4;
    localparam int COUNT_W    = 4;
    localparam int INDEX_W    = 3;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_SIZE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WORKER_COUNT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WORKER_INDEX = 2'd2;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_DIV,
        ST_MAC,
        ST_DRAIN
    } rbmm_state_t;

endpackage

// File: rtl/rbmm_operand_if.sv
// ----------------------------------------------------------------------------
// rbmm_operand_if
// Input channel: one pair of A and B elements per item.
// ----------------------------------------------------------------------------
interface rbmm_operand_if;

    logic                                   valid;
    logic                                   ready;
    logic signed [rbmm_pkg::ELEM_W-1:0]     a_element;
    logic signed [rbmm_pkg::ELEM_W-1:0]     b_element;

    modport source (output valid, output a_element, output b_element, input ready);
    modport sink   (input valid, input a_element, input b_element, output ready);

endinterface

// File: rtl/rbmm_result_if.sv
// ----------------------------------------------------------------------------
// rbmm_result_if
// Output channel: one element of the result band per item.
// ----------------------------------------------------------------------------
interface rbmm_result_if;

    logic                                   valid;
    logic                                   ready;
    logic        [rbmm_pkg::ROW_W-1:0]      row;
    logic        [rbmm_pkg::ROW_W-1:0]      column;
    logic signed [rbmm_pkg::SUM_W-1:0]      product_sum;
    logic                                   last;

    modport source (output valid, output row, output column, output product_sum,
                    output last, input ready);
    modport sink   (input valid, input row, input column, input product_sum,
                    input last, output ready);

endinterface

// File: rtl/rbmm_cfg_if.sv
// ----------------------------------------------------------------------------
// rbmm_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface rbmm_cfg_if;

    logic                                   valid;
    logic                                   ready;
    logic [rbmm_pkg::CFG_IDX_W-1:0]         index;
    logic [rbmm_pkg::CFG_DATA_W-1:0]        data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

// File: rtl/rbmm_ram.sv
// ----------------------------------------------------------------------------
// rbmm_ram
// Generic simple dual port RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module rbmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/row_band_matrix_multiply_core.sv
// ----------------------------------------------------------------------------
// row_band_matrix_multiply_core
// Loads two n x n matrices pair by pair, then emits its row band of C = A*B.
// ----------------------------------------------------------------------------
// Loading accepts items only in the load state; the item that completes the
// matrices is followed, for a worker index below the worker count, by a row
// split (repeated subtraction of the worker count), during which no item is
// taken. Each result element then reads one A and one B entry per cycle from
// the two element RAMs into the single multiply-accumulate path, n reads in
// all, waits for the read and product registers to empty, and moves the sum
// into the output register once that register is free or being read out. A
// band of rows x n elements is finished this way before the next load starts;
// the last result may still wait in the output register while the next
// matrices are loading. A worker index at or above the worker count loads but emits nothing.
// ----------------------------------------------------------------------------
module row_band_matrix_multiply_core #(
    parameter int MAX_SIZE = rbmm_pkg::MAX_SIZE
) (
    input  logic          clk,
    input  logic          rst_n,
    rbmm_cfg_if.sink      cfg,
    rbmm_operand_if.sink  operands,
    rbmm_result_if.source results
);

    localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(MAX_SIZE + 1);
    localparam int PW     = 2 * CNT_W;
    localparam int LC_W   = $clog2(DEPTH + 1);
    localparam int SW     = CNT_W + rbmm_pkg::INDEX_W + 1;

    rbmm_pkg::rbmm_state_t state_reg, state_next;

    logic [rbmm_pkg::SIZE_W-1:0]  matrix_size_reg;
    logic [rbmm_pkg::COUNT_W-1:0] worker_count_reg;
    logic [rbmm_pkg::INDEX_W-1:0] worker_index_reg;

    logic [LC_W-1:0]  load_count_reg, load_count_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] base_reg, base_next;
    logic [CNT_W-1:0] r_reg, r_next;
    logic [CNT_W-1:0] row_last_reg, row_last_next;
    logic [CNT_W-1:0] j_reg, j_next;
    logic [CNT_W-1:0] k_reg, k_next;

    logic rd_valid_reg;
    logic prod_valid_reg;
    logic out_valid_reg, out_valid_next;

    logic signed [rbmm_pkg::PROD_W-1:0] prod_reg;
    logic signed [rbmm_pkg::SUM_W-1:0]  acc_reg;
    logic        [rbmm_pkg::ROW_W-1:0]  out_row_reg;
    logic        [rbmm_pkg::ROW_W-1:0]  out_column_reg;
    logic signed [rbmm_pkg::SUM_W-1:0]  out_sum_reg;
    logic                               out_last_reg;

    logic [CNT_W-1:0]             n_eff;
    logic [rbmm_pkg::COUNT_W-1:0] cnt_eff;
    logic [PW-1:0]                total;
    logic [LC_W-1:0]              wa;
    logic [LC_W-1:0]              wa_inc;
    logic                         cfg_wr;
    logic                         in_acc;
    logic                         mem_we;
    logic                         rd_issue;
    logic                         out_load;
    logic                         acc_clr;
    logic                         elem_last;
    logic [SW-1:0]                start_wide;
    logic [CNT_W-1:0]             start_calc;
    logic [CNT_W-1:0]             rows_calc;
    logic                         idx_below_rem;
    logic [PW-1:0]                a_addr_wide;
    logic [PW-1:0]                b_addr_wide;
    logic [rbmm_pkg::ELEM_W-1:0]  a_q;
    logic [rbmm_pkg::ELEM_W-1:0]  b_q;

    // effective size and worker count
    always_comb
    begin
        if (matrix_size_reg == '0)
        begin
            n_eff = CNT_W'(1);
        end
        else if (matrix_size_reg > rbmm_pkg::SIZE_W'(MAX_SIZE))
        begin
            n_eff = CNT_W'(MAX_SIZE);
        end
        else
        begin
            n_eff = CNT_W'(matrix_size_reg);
        end
        cnt_eff = (worker_count_reg == '0) ? rbmm_pkg::COUNT_W'(1) : worker_count_reg;
    end

    assign total  = PW'(n_eff) * PW'(n_eff);
    assign wa     = (PW'(load_count_reg) >= total) ? '0 : load_count_reg;
    assign wa_inc = wa + LC_W'(1);

    assign cfg.ready      = 1'b1;
    assign cfg_wr         = cfg.valid && cfg.ready;
    assign operands.ready = (state_reg == rbmm_pkg::ST_LOAD);
    assign in_acc         = operands.valid && operands.ready;

    // band placement from the finished division
    assign idx_below_rem = (CNT_W'(worker_index_reg) < rem_reg)
                           && (rbmm_pkg::INDEX_W'(rem_reg) > worker_index_reg
                               || CNT_W > rbmm_pkg::INDEX_W);
    always_comb
    begin
        start_wide = SW'(worker_index_reg) * SW'(base_reg)
                   + (idx_below_rem ? SW'(worker_index_reg) : SW'(rem_reg));
        start_calc = CNT_W'(start_wide);
        rows_calc  = base_reg + (idx_below_rem ? CNT_W'(1) : CNT_W'(0));
    end

    assign elem_last = (j_reg == n_eff - CNT_W'(1)) && (r_reg == row_last_reg);

    always_comb
    begin
        state_next      = state_reg;
        load_count_next = load_count_reg;
        rem_next        = rem_reg;
        base_next       = base_reg;
        r_next          = r_reg;
        row_last_next   = row_last_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        mem_we          = 1'b0;
        rd_issue        = 1'b0;
        out_load        = 1'b0;
        acc_clr         = 1'b0;

        case (state_reg)
            rbmm_pkg::ST_LOAD:
            begin
                if (in_acc)
                begin
                    mem_we = 1'b1;
                    if (PW'(wa_inc) == total)
                    begin
                        load_count_next = '0;
                        if (rbmm_pkg::COUNT_W'(worker_index_reg) < cnt_eff)
                        begin
                            state_next = rbmm_pkg::ST_DIV;
                            rem_next   = n_eff;
                            base_next  = '0;
                        end
                    end
                    else
                    begin
                        load_count_next = wa_inc;
                    end
                end
            end
            rbmm_pkg::ST_DIV:
            begin
                if ((rbmm_pkg::COUNT_W + CNT_W)'(rem_reg)
                    >= (rbmm_pkg::COUNT_W + CNT_W)'(cnt_eff))
                begin
                    rem_next  = CNT_W'((rbmm_pkg::COUNT_W + CNT_W)'(rem_reg)
                                       - (rbmm_pkg::COUNT_W + CNT_W)'(cnt_eff));
                    base_next = base_reg + CNT_W'(1);
                end
                else if (rows_calc == '0)
                begin
                    state_next = rbmm_pkg::ST_LOAD;
                end
                else
                begin
                    r_next        = start_calc;
                    row_last_next = start_calc + rows_calc - CNT_W'(1);
                    j_next        = '0;
                    k_next        = '0;
                    acc_clr       = 1'b1;
                    state_next    = rbmm_pkg::ST_MAC;
                end
            end
            rbmm_pkg::ST_MAC:
            begin
                rd_issue = 1'b1;
                if (k_reg == n_eff - CNT_W'(1))
                begin
                    state_next = rbmm_pkg::ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                end
            end
            rbmm_pkg::ST_DRAIN:
            begin
                if (!rd_valid_reg && !prod_valid_reg && (!out_valid_reg || results.ready))
                begin
                    out_load = 1'b1;
                    acc_clr  = 1'b1;
                    k_next   = '0;
                    if (j_reg == n_eff - CNT_W'(1))
                    begin
                        j_next = '0;
                        if (r_reg == row_last_reg)
                        begin
                            state_next = rbmm_pkg::ST_LOAD;
                        end
                        else
                        begin
                            r_next     = r_reg + CNT_W'(1);
                            state_next = rbmm_pkg::ST_MAC;
                        end
                    end
                    else
                    begin
                        j_next     = j_reg + CNT_W'(1);
                        state_next = rbmm_pkg::ST_MAC;
                    end
                end
            end
            default:
            begin
                state_next = rbmm_pkg::ST_LOAD;
            end
        endcase

        // new size restarts loading
        if (cfg_wr && cfg.index == rbmm_pkg::REG_MATRIX_SIZE)
        begin
            load_count_next = '0;
        end
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rbmm_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_count_reg <= '0;
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            load_count_reg <= load_count_next;
            rd_valid_reg   <= rd_issue;
            prod_valid_reg <= rd_valid_reg;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg  <= rbmm_pkg::SIZE_W'(8);
            worker_count_reg <= rbmm_pkg::COUNT_W'(1);
            worker_index_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg.index)
                rbmm_pkg::REG_MATRIX_SIZE:
                begin
                    matrix_size_reg <= cfg.data;
                end
                rbmm_pkg::REG_WORKER_COUNT:
                begin
                    worker_count_reg <= cfg.data;
                end
                rbmm_pkg::REG_WORKER_INDEX:
                begin
                    worker_index_reg <= cfg.data[rbmm_pkg::INDEX_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        base_reg     <= base_next;
        r_reg        <= r_next;
        row_last_reg <= row_last_next;
        j_reg        <= j_next;
        k_reg        <= k_next;
        if (rd_valid_reg)
        begin
            prod_reg <= $signed(a_q) * $signed(b_q);
        end
        if (acc_clr)
        begin
            acc_reg <= '0;
        end
        else if (prod_valid_reg)
        begin
            acc_reg <= acc_reg + rbmm_pkg::SUM_W'(prod_reg);
        end
        if (out_load)
        begin
            out_row_reg    <= rbmm_pkg::ROW_W'(r_reg);
            out_column_reg <= rbmm_pkg::ROW_W'(j_reg);
            out_sum_reg    <= acc_reg;
            out_last_reg   <= elem_last;
        end
    end

    assign a_addr_wide = PW'(r_reg) * PW'(n_eff) + PW'(k_reg);
    assign b_addr_wide = PW'(k_reg) * PW'(n_eff) + PW'(j_reg);

    rbmm_ram #(
        .WIDTH (rbmm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ADDR_W'(wa)),
        .wdata (operands.a_element),
        .re    (rd_issue),
        .raddr (ADDR_W'(a_addr_wide)),
        .rdata (a_q)
    );

    rbmm_ram #(
        .WIDTH (rbmm_pkg::ELEM_W),
        .DEPTH (DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (ADDR_W'(wa)),
        .wdata (operands.b_element),
        .re    (rd_issue),
        .raddr (ADDR_W'(b_addr_wide)),
        .rdata (b_q)
    );

    assign results.valid       = out_valid_reg;
    assign results.row         = out_row_reg;
    assign results.column      = out_column_reg;
    assign results.product_sum = out_sum_reg;
    assign results.last        = out_last_reg;

    a_load_count_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        PW'(load_count_reg) < total
    ) else $error("load count reached matrix size");

    a_pipe_empty_in_load: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg == rbmm_pkg::ST_LOAD |-> !rd_valid_reg && !prod_valid_reg
    ) else $error("multiply pipeline busy while loading");

    a_mac_in_band: assert property (
        @(posedge clk) disable iff (!rst_n)
        state_reg == rbmm_pkg::ST_MAC |-> r_reg <= row_last_reg && k_reg < n_eff
    ) else $error("read index outside band");

    a_last_ends_band: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_load && elem_last |=> state_reg == rbmm_pkg::ST_LOAD
    ) else $error("band did not end after last element");

endmodule
